@@ src/sid_pkg.sv @@
// Shared constants for the signed integer to radix digits block.
// Field widths, symbol codes, register indexes and parameter defaults.
// No dependencies.
package sid_pkg;

  localparam int VALUE_W  = 32;
  localparam int RADIX_W  = 5;
  localparam int SYMBOL_W = 8;
  localparam int TABLE_W  = 64;
  localparam int TABLE_N  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int DIGIT_SLOTS_DEF = 32;

  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [TABLE_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [TABLE_W-1:0] SYMBOLS_HIGH_RESET = 64'h4645444342413938;

  typedef struct packed {
    logic done;
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] remainder;
  } div_result_t;

endpackage

@@ src/sid_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides a 32-bit magnitude by the radix; uses sid_pkg.
module sid_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sid_pkg::VALUE_W-1:0]   dividend,
  input  logic [sid_pkg::RADIX_W-1:0]   divisor,
  output sid_pkg::div_result_t          result
);
  import sid_pkg::*;

  localparam int STEP_W = $clog2(VALUE_W);

  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] quo;
  logic [RADIX_W-1:0] rem;

  logic [RADIX_W-1:0] trial;
  logic               fits;

  // remainder stays below the divisor, so shifting one bit in fits RADIX_W bits
  always_comb begin
    trial = {rem[RADIX_W-2:0], quo[VALUE_W-1]};
    fits  = (trial >= divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(VALUE_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], fits};
      rem <= fits ? (trial - divisor) : trial;
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule

@@ src/signed_integer_to_radix_digits_core.sv @@
// Top level: converts a signed 32-bit value to text in a configurable radix.
// Uses sid_pkg and sid_div.
//
//  channel | dir | fields
//  s_*     | in  | tdata = value (32, signed)
//  m_*     | out | tdata = character (8), tlast = last
//  cfg_*   | in  | index 0 radix, 1 symbols_low, 2 symbols_high
//
// One item at a time: the value is accepted, the symbol table is checked row by
// row, each digit comes from the bit-serial divider, then a minus sign goes out
// for a negative value and each digit character is read from the digit memory
// and then loaded.
// Synchronous reset clears control state; the digit memory is not cleared.
// A stalled output holds the current character and pauses the emission.
module signed_integer_to_radix_digits_core #(
  parameter int MAX_SYMBOLS = sid_pkg::MAX_SYMBOLS_DEF,
  parameter int DIGIT_SLOTS = sid_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [sid_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sid_pkg::SYMBOL_W-1:0]       m_tdata,   // [7:0] character
  output logic                               m_tlast,   // last
  input  logic                               cfg_we,
  input  logic [sid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sid_pkg::TABLE_W-1:0]        cfg_data
);
  import sid_pkg::*;

  localparam int CNT_W  = $clog2(DIGIT_SLOTS + 1);
  localparam int ADDR_W = $clog2(DIGIT_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [RADIX_W-1:0]  radix;
  logic [TABLE_W-1:0]  symbols_low;
  logic [TABLE_W-1:0]  symbols_high;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic                neg;
  logic [VALUE_W-1:0]  mag;
  logic [3:0]          row;
  logic [CNT_W-1:0]    digit_count;
  logic [CNT_W-1:0]    pos;

  logic [3:0]          digit_store [DIGIT_SLOTS];
  logic [3:0]          rd_data;

  div_result_t         div_res;
  logic                div_start;
  logic [VALUE_W-1:0]  div_dividend;

  logic                in_accept;
  logic                radix_ok;
  logic                row_bad;
  logic                row_last;
  logic                out_free;
  logic                more_digits;
  logic [CNT_W-1:0]    count_inc;

  function automatic logic [SYMBOL_W-1:0] symbol_at(input logic [TABLE_W-1:0] lo,
                                                    input logic [TABLE_W-1:0] hi,
                                                    input logic [3:0] k);
    logic [2*TABLE_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{k, 3'b000} +: SYMBOL_W];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:        radix        <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign radix_ok  = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_SYMBOLS));
  assign out_free  = !m_tvalid || m_tready;
  assign row_last  = (row == 4'(radix - 1'b1));
  assign count_inc = digit_count + 1'b1;
  assign more_digits = (div_res.quotient != '0) && (count_inc < CNT_W'(DIGIT_SLOTS));

  // one table row a cycle: symbol row against sign codes and every later symbol in use
  always_comb begin
    logic [SYMBOL_W-1:0] s;
    s = symbol_at(symbols_low, symbols_high, row);
    row_bad = (s == SYM_MINUS) || (s == SYM_PLUS);
    for (int b = 0; b < TABLE_N; b++) begin
      if ((5'(b) > {1'b0, row}) && (5'(b) < radix) &&
          (symbol_at(symbols_low, symbols_high, 4'(b)) == s)) begin
        row_bad = 1'b1;
      end
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag;
    if (state == ST_CHECK && !row_bad && row_last) begin
      div_start = 1'b1;
    end else if (state == ST_DIV && div_res.done && more_digits) begin
      div_start    = 1'b1;
      div_dividend = div_res.quotient;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_accept && radix_ok) state_next = ST_CHECK;
      ST_CHECK: begin
        if (row_bad) state_next = ST_IDLE;
        else if (row_last) state_next = ST_DIV;
      end
      ST_DIV:   if (div_res.done && !more_digits) state_next = neg ? ST_SIGN : ST_READ;
      ST_SIGN:  if (out_free) state_next = ST_READ;
      ST_READ:  state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = (pos == CNT_W'(1)) ? ST_IDLE : ST_READ;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
      pos         <= '0;
      row         <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (((state == ST_SIGN) || (state == ST_EMIT)) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          row <= '0;
          if (in_accept) digit_count <= '0;
        end
        ST_CHECK: begin
          row <= row + 1'b1;
          if (row_bad) digit_count <= '0;
        end
        ST_DIV: begin
          if (div_res.done) begin
            digit_count <= count_inc;
            pos         <= count_inc;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            pos <= pos - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: sign flag, magnitude, the output character and its last flag
  always_ff @(posedge clk) begin
    if (in_accept) begin
      neg <= s_tdata[VALUE_W-1];
      mag <= s_tdata[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_tdata)) : VALUE_W'(s_tdata);
    end
    if (state == ST_SIGN && out_free) begin
      m_tdata <= SYM_MINUS;
      m_tlast <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tdata <= symbol_at(symbols_low, symbols_high, rd_data);
      m_tlast <= (pos == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_res.done) begin
      digit_store[digit_count[ADDR_W-1:0]] <= div_res.remainder[3:0];
    end
    rd_data <= digit_store[ADDR_W'(pos - 1'b1)];
  end

  sid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix),
    .result   (div_res)
  );

endmodule

@@ tb/sv/signed_integer_to_radix_digits_core_tb.sv @@
// Testbench for signed_integer_to_radix_digits_core: random and directed values
// through the stream ports, predicted text checked by a scoreboard class.
// Depends on sid_pkg and the core RTL only.
module signed_integer_to_radix_digits_core_tb;
  import sid_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 410;
  localparam int CALM_TAIL     = 40;
  // slowest value: a negative value with 32 binary digits, rounded up
  localparam int DRAIN_CYCLES  = 1200;
  localparam int STUCK_LIMIT   = 8000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [SYMBOL_W-1:0] ch;
    logic                last;
  } text_char_t;

  class radix_text_board;
    logic [RADIX_W-1:0] radix;
    logic [TABLE_W-1:0] sym_lo;
    logic [TABLE_W-1:0] sym_hi;
    text_char_t         chars_due[$];
    int                 errors;

    function new();
      radix  = RADIX_RESET;
      sym_lo = SYMBOLS_LOW_RESET;
      sym_hi = SYMBOLS_HIGH_RESET;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TABLE_W-1:0] d);
      case (idx)
        CFG_RADIX:        radix  = d[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  sym_lo = d;
        CFG_SYMBOLS_HIGH: sym_hi = d;
        default: ;
      endcase
    endfunction

    function logic [SYMBOL_W-1:0] symbol(int k);
      return (k < 8) ? sym_lo[8*k +: 8] : sym_hi[8*(k-8) +: 8];
    endfunction

    function bit table_usable();
      logic [SYMBOL_W-1:0] s;
      if (radix < 2 || radix > MAX_SYMBOLS_DEF) return 1'b0;
      for (int a = 0; a < radix; a++) begin
        s = symbol(a);
        if (s == SYM_MINUS || s == SYM_PLUS) return 1'b0;
        for (int b = a + 1; b < radix; b++)
          if (symbol(b) == s) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Expected text of one accepted value, sign first, digits most significant first.
    function void note_value(logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      logic [3:0]         digits[DIGIT_SLOTS_DEF];
      int                 cnt;
      text_char_t         t;
      if (!table_usable()) return;
      base = {{(VALUE_W-RADIX_W){1'b0}}, radix};
      mag  = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
      cnt  = 0;
      do begin
        digits[cnt] = 4'(mag % base);
        cnt++;
        mag = mag / base;
      end while (mag != 0);
      if (raw[VALUE_W-1]) begin
        t.ch   = SYM_MINUS;
        t.last = 1'b0;
        chars_due.push_back(t);
      end
      for (int k = cnt - 1; k >= 0; k--) begin
        t.ch   = symbol(digits[k]);
        t.last = (k == 0);
        chars_due.push_back(t);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_char(logic [SYMBOL_W-1:0] c, logic l);
      text_char_t want;
      if (chars_due.size() == 0) begin
        report($sformatf("character 0x%02h last %0b with nothing expected", c, l));
        return;
      end
      want = chars_due.pop_front();
      if (c !== want.ch)
        report($sformatf("character 0x%02h, expected 0x%02h", c, want.ch));
      if (l !== want.last)
        report($sformatf("last %0b on character 0x%02h, expected %0b", l, c, want.last));
    endtask

    function int pending();
      return chars_due.size();
    endfunction

    task finish_check();
      if (chars_due.size() != 0)
        report($sformatf("%0d characters never arrived", chars_due.size()));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic signed [VALUE_W-1:0]   s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b1;
  logic [SYMBOL_W-1:0]         m_tdata;
  logic                        m_tlast;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [TABLE_W-1:0]          cfg_data = '0;

  radix_text_board     text_board = new();
  logic [SYMBOL_W-1:0] sym_tab[TABLE_N];
  bit                  calm = 1'b0;
  bit                  steady = 1'b0;
  int                  stuck_cycles = 0;

  signed_integer_to_radix_digits_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Sample both handshakes and watch for a hang.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) text_board.note_value(s_tdata);
    if (!rst && m_tvalid && m_tready) text_board.check_char(m_tdata, m_tlast);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("signed_integer_to_radix_digits_core_tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Output stalls in bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && !steady && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    s_tdata  <= v;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Wait for all text, then let a silent item finish before touching registers.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (text_board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [TABLE_W-1:0] rword, lo, hi, input bit poke);
    logic [TABLE_W-1:0] spare;
    spare = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RADIX;
    cfg_data  <= rword;
    @(posedge clk);
    text_board.set_register(CFG_RADIX, rword);
    cfg_index <= CFG_SYMBOLS_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    text_board.set_register(CFG_SYMBOLS_LOW, lo);
    cfg_index <= CFG_SYMBOLS_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    text_board.set_register(CFG_SYMBOLS_HIGH, hi);
    if (poke) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= spare;
      @(posedge clk);
      text_board.set_register(CFG_SPARE, spare);
    end
    cfg_we <= 1'b0;
  endtask

  // Distinct symbols for the digits in use, anything above them; optionally spoil one.
  function automatic void pick_symbols(int r, bit broken);
    bit [255:0]          taken;
    logic [SYMBOL_W-1:0] b;
    int                  i;
    int                  j;
    taken = '0;
    taken[SYM_PLUS]  = 1'b1;
    taken[SYM_MINUS] = 1'b1;
    for (int k = 0; k < TABLE_N; k++) begin
      if (k < r) begin
        do b = 8'($urandom_range(0, 255)); while (taken[b]);
        taken[b] = 1'b1;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      sym_tab[k] = b;
    end
    if (broken) begin
      j = $urandom_range(1, r - 1);
      i = $urandom_range(0, j - 1);
      case ($urandom_range(0, 2))
        0:       sym_tab[j] = sym_tab[i];
        1:       sym_tab[i] = SYM_PLUS;
        default: sym_tab[j] = SYM_MINUS;
      endcase
    end
  endfunction

  function automatic logic [TABLE_W-1:0] table_word(int base);
    logic [TABLE_W-1:0] w;
    for (int k = 0; k < 8; k++) w[8*k +: 8] = sym_tab[base + k];
    return w;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value(int r);
    logic [VALUE_W-1:0] v;
    longint             p;
    int                 hops;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        // land on or just below a power of the radix, where the digit count steps
        if (r < 2) begin
          v = $urandom;
        end else begin
          p    = 1;
          hops = $urandom_range(1, 31);
          while (hops > 0 && p * r <= 64'sd2147483648) begin
            p = p * r;
            hops--;
          end
          v = 32'(p - $urandom_range(0, 1));
          if ($urandom_range(0, 1)) v = 32'd0 - v;
        end
      end
    endcase
    return v;
  endfunction

  initial begin
    int                 sent;
    int                 r;
    int                 n_items;
    bit                 broken;
    bit                 bad_radix;
    logic [TABLE_W-1:0] rword;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: decimal
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd10);
    send_value(32'hFFFF_FFF6);
    send_value(32'd123456789);
    settle();

    // binary; unused symbols hold sign characters
    apply_config(64'd2, 64'h2D2B_2D2B_2D2B_3130, 64'h2D2D_2D2D_2D2D_2D2D, 1'b0);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    send_value(32'd5);
    send_value(32'hFFFF_FFFF);
    settle();

    // full table with a zero byte and a 0xFF symbol; radix word has junk upper bits
    apply_config(64'hFFFF_FFFF_FFFF_FFF0, 64'h6665_6463_6261_FF00,
                 64'h7A79_7877_7675_7473, 1'b0);
    send_value(32'hDEAD_BEEF);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd255);
    settle();

    // radix out of range: no text
    apply_config(64'd0, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'd1);
    settle();
    apply_config(64'd1, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'd7);
    settle();
    apply_config(64'd17, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'd3);
    settle();
    apply_config(64'd31, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'hFFFF_FFFB);
    settle();

    // repeated symbol
    apply_config(64'd4, 64'h3736_3534_3331_3130, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'd100);
    settle();

    // plus sign as the first symbol, minus sign as the last one in use
    apply_config(64'd3, 64'h3736_3534_3332_312B, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'd4);
    settle();
    apply_config(64'd3, 64'h3736_3534_332D_3130, SYMBOLS_HIGH_RESET, 1'b0);
    send_value(32'd4);
    settle();

    // minus sign beyond the radix is harmless; spare register index does nothing
    apply_config(64'd10, SYMBOLS_LOW_RESET, 64'h4645_442D_4241_3938, 1'b1);
    send_value(32'hFFFF_FFB3);
    send_value(32'd12345);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       r = 2;
        1:       r = 16;
        default: r = $urandom_range(2, 16);
      endcase
      n_items   = $urandom_range(0, 19);
      bad_radix = (n_items < 2);
      broken    = (n_items >= 2 && n_items < 4);
      pick_symbols(r, broken);
      rword = {$urandom, $urandom};
      if (bad_radix) begin
        r = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
      end
      rword[RADIX_W-1:0] = r[RADIX_W-1:0];
      apply_config(rword, table_word(0), table_word(8), $urandom_range(0, 7) == 0);
      if (bad_radix || broken) n_items = 3;
      else if (r <= 3) n_items = 10;
      else n_items = 30;
      for (int k = 0; k < n_items; k++) begin
        calm = (RANDOM_ITEMS - sent <= CALM_TAIL);
        send_value(rand_value(r));
        if (!bad_radix && !broken) sent++;
      end
      settle();
    end

    text_board.finish_check();
    if (text_board.errors == 0) begin
      $display("signed_integer_to_radix_digits_core_tb: PASS");
    end else begin
      $display("signed_integer_to_radix_digits_core_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/sid_pkg.sv
src/sid_div.sv
src/signed_integer_to_radix_digits_core.sv
tb/sv/signed_integer_to_radix_digits_core_tb.sv
